[design/fractal_value_noise_assert.svh]
// assertion macros used by the fractal value noise port checks
`ifndef FRACTAL_VALUE_NOISE_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define FVN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fractal value noise check failed");

// next-cycle implication, held off while reset is low
`define FVN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fractal value noise check failed");

`endif

[design/fvn_pkg.sv]
// types, constants and helper functions for the fractal value noise block
package fvn_pkg;

    localparam int DEF_MAX_OCTAVES = 8;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int IN_W    = 32;
    localparam int OCT_W   = 4;
    localparam int NOISE_W = 18;
    localparam int COORD_W = 40;
    localparam int SUM_W   = 27;
    localparam int CORN_W  = 24;
    localparam int RECIP_W = 18;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [31:0] K_HASH_X  = 32'h9e3779b9;
    localparam logic [31:0] K_HASH_Y  = 32'h85ebca6b;
    localparam logic [31:0] K_MIX_A   = 32'h7feb352d;
    localparam logic [31:0] K_MIX_B   = 32'h846ca68b;
    localparam logic [31:0] SEED_STEP = 32'd1013;
    localparam logic [17:0] SCALE_Q16 = 18'd133038;
    localparam logic [17:0] SMOOTH_K  = 18'd196608;
    localparam int          NOISE_MAX = 65536;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_op;

    function automatic logic [31:0] xs16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

    // round(2^(16+k) / (2^k - 1)) for k octaves
    function automatic logic [RECIP_W-1:0] recip(input logic [OCT_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd2:    r = 18'd87381;
            4'd3:    r = 18'd74898;
            4'd4:    r = 18'd69905;
            4'd5:    r = 18'd67650;
            4'd6:    r = 18'd66576;
            4'd7:    r = 18'd66052;
            4'd8:    r = 18'd65793;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

[design/fvn_mul.sv]
// shared signed multiplier with registered product
module fvn_mul (
    input  logic                              i_clk,
    input  fvn_pkg::t_mul_op                  i_op,
    output logic signed [fvn_pkg::PROD_W-1:0] o_prod
);
    import fvn_pkg::*;

    always_ff @(posedge i_clk) begin
        o_prod <= PROD_W'($signed(i_op.a) * $signed(i_op.b));
    end

endmodule

[design/fractal_value_noise.sv]
// fractal value noise top level: step sequencer around one shared 33x33 multiplier
// an accepted start runs K octave passes, then S_NORM and S_OUT, which raises o_valid; K = clamped octaves
// a new request is taken only in S_IDLE, after the last result; the result strobe is never stalled
// each octave is 24 steps with 23 multiplies: hashes, mixer, smoothsteps, lerps, 2.03 scale
// reset: synchronous active low, clears the sequencer, busy and the result strobe
module fractal_value_noise #(
    parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES,
    parameter int FRAC_BITS   = fvn_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [fvn_pkg::IN_W-1:0]    i_point_x,
    input  logic signed [fvn_pkg::IN_W-1:0]    i_point_y,
    input  logic [fvn_pkg::IN_W-1:0]           i_noise_seed,
    input  logic [fvn_pkg::OCT_W-1:0]          i_octave_count,
    output logic                               o_valid,
    output logic signed [fvn_pkg::NOISE_W-1:0] o_noise_value
);
    import fvn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_OCT, S_NORM, S_OUT} t_state;

    // step codes, named after what goes into the multiplier
    localparam logic [4:0] SP_TTX  = 5'd0;
    localparam logic [4:0] SP_HX0  = 5'd1;
    localparam logic [4:0] SP_SMX  = 5'd2;
    localparam logic [4:0] SP_HX1  = 5'd3;
    localparam logic [4:0] SP_TTY  = 5'd4;
    localparam logic [4:0] SP_HY0  = 5'd5;
    localparam logic [4:0] SP_SMY  = 5'd6;
    localparam logic [4:0] SP_HY1  = 5'd7;
    localparam logic [4:0] SP_C00A = 5'd8;
    localparam logic [4:0] SP_C00B = 5'd9;
    localparam logic [4:0] SP_C10A = 5'd10;
    localparam logic [4:0] SP_C10B = 5'd11;
    localparam logic [4:0] SP_C01A = 5'd12;
    localparam logic [4:0] SP_C01B = 5'd13;
    localparam logic [4:0] SP_C11A = 5'd14;
    localparam logic [4:0] SP_C11B = 5'd15;
    localparam logic [4:0] SP_TOP  = 5'd16;
    localparam logic [4:0] SP_BOT  = 5'd17;
    localparam logic [4:0] SP_XLO  = 5'd18;
    localparam logic [4:0] SP_XHI  = 5'd19;
    localparam logic [4:0] SP_VAL  = 5'd20;
    localparam logic [4:0] SP_YLO  = 5'd21;
    localparam logic [4:0] SP_YHI  = 5'd22;
    localparam logic [4:0] SP_LAST = 5'd23;

    localparam logic signed [PROD_W-1:0] SAT_HI    = PROD_W'(NOISE_MAX);
    localparam logic signed [PROD_W-1:0] SAT_LO    = -SAT_HI;
    localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(1 << 23);
    localparam logic signed [25:0]       HALF_Q24  = 26'sh1000000;

    t_state                     r_state;
    logic [4:0]                 r_step;
    logic                       r_busy;
    logic                       r_valid;
    logic signed [NOISE_W-1:0]  r_noise;
    logic [OCT_W-1:0]           r_k;
    logic [OCT_W-1:0]           r_oct;
    logic signed [COORD_W-1:0]  r_x;
    logic signed [COORD_W-1:0]  r_y;
    logic [31:0]                r_seed;
    logic [31:0]                r_tt;
    logic [31:0]                r_hx0;
    logic [31:0]                r_hx1;
    logic [31:0]                r_hy0;
    logic [31:0]                r_hy1;
    logic [16:0]                r_sx;
    logic [16:0]                r_sy;
    logic [CORN_W-1:0]          r_c00;
    logic [CORN_W-1:0]          r_c10;
    logic [CORN_W-1:0]          r_c01;
    logic [CORN_W-1:0]          r_c11;
    logic [CORN_W-1:0]          r_top;
    logic [CORN_W-1:0]          r_bot;
    logic [37:0]                r_plo;
    logic signed [SUM_W-1:0]    r_sum;

    logic signed [PROD_W-1:0]   r_prod;
    t_mul_op                    w_op;

    logic signed [COORD_W-1:0]  w_xs;
    logic signed [COORD_W-1:0]  w_ys;
    logic [31:0]                w_x0;
    logic [31:0]                w_x1;
    logic [31:0]                w_y0;
    logic [31:0]                w_y1;
    logic [15:0]                w_tx;
    logic [15:0]                w_ty;
    logic [31:0]                w_m;
    logic [31:0]                w_mixed;
    logic [CORN_W-1:0]          w_corner;
    logic signed [PROD_W-1:0]   w_sh;
    logic [CORN_W-1:0]          w_v;
    logic signed [25:0]         w_n;
    logic signed [25:0]         w_term;
    logic [4:0]                 w_shamt;
    logic [PROD_W-1:0]          w_full;
    logic [COORD_W-1:0]         w_coord;
    logic signed [24:0]         w_dtop;
    logic signed [24:0]         w_dbot;
    logic signed [24:0]         w_dval;
    logic signed [PROD_W-1:0]   w_round;
    logic signed [NOISE_W-1:0]  w_sat;
    logic [OCT_W-1:0]           w_k;

    fvn_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .o_prod (r_prod)
    );

    // lattice cell and Q0.16 fraction of the current coordinates
    assign w_xs = r_x >>> FRAC_BITS;
    assign w_ys = r_y >>> FRAC_BITS;
    assign w_x0 = w_xs[31:0];
    assign w_y0 = w_ys[31:0];
    assign w_x1 = w_x0 + 32'd1;
    assign w_y1 = w_y0 + 32'd1;

    if (FRAC_BITS >= 16) begin : g_frac_trunc
        assign w_tx = r_x[FRAC_BITS-1 -: 16];
        assign w_ty = r_y[FRAC_BITS-1 -: 16];
    end else begin : g_frac_pad
        assign w_tx = {r_x[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
        assign w_ty = {r_y[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
    end

    assign w_m      = r_prod[31:0];
    assign w_mixed  = xs16(w_m);
    assign w_corner = w_mixed[CORN_W-1:0];
    assign w_sh     = r_prod >>> 16;
    assign w_v      = r_top + w_sh[CORN_W-1:0];
    assign w_n      = $signed({1'b0, w_v, 1'b0}) - HALF_Q24;
    assign w_shamt  = {1'b0, r_oct} + 5'd1;
    assign w_term   = w_n >>> w_shamt;

    // scaled coordinate from the high partial (in the product) and the low partial
    assign w_full  = (r_prod <<< 20) + {28'b0, r_plo};
    assign w_coord = w_full[55:16];

    assign w_dtop = $signed({1'b0, r_c10}) - $signed({1'b0, r_c00});
    assign w_dbot = $signed({1'b0, r_c11}) - $signed({1'b0, r_c01});
    assign w_dval = $signed({1'b0, r_bot}) - $signed({1'b0, r_top});

    assign w_round = (r_prod + ROUND_ADD) >>> 24;
    always_comb begin
        if (w_round > SAT_HI) begin
            w_sat = SAT_HI[NOISE_W-1:0];
        end else if (w_round < SAT_LO) begin
            w_sat = SAT_LO[NOISE_W-1:0];
        end else begin
            w_sat = w_round[NOISE_W-1:0];
        end
    end

    always_comb begin
        if (i_octave_count == '0) begin
            w_k = OCT_W'(1);
        end else if (i_octave_count > OCT_W'(MAX_OCTAVES)) begin
            w_k = OCT_W'(MAX_OCTAVES);
        end else begin
            w_k = i_octave_count;
        end
    end

    // multiplier operand select
    always_comb begin
        w_op.a = '0;
        w_op.b = '0;
        case (r_state)
            S_OCT: begin
                case (r_step)
                    SP_TTX: begin
                        w_op.a = {17'b0, w_tx};
                        w_op.b = {17'b0, w_tx};
                    end
                    SP_HX0: begin
                        w_op.a = {1'b0, w_x0};
                        w_op.b = {1'b0, K_HASH_X};
                    end
                    SP_SMX: begin
                        w_op.a = {1'b0, r_tt};
                        w_op.b = {15'b0, SMOOTH_K - {1'b0, w_tx, 1'b0}};
                    end
                    SP_HX1: begin
                        w_op.a = {1'b0, w_x1};
                        w_op.b = {1'b0, K_HASH_X};
                    end
                    SP_TTY: begin
                        w_op.a = {17'b0, w_ty};
                        w_op.b = {17'b0, w_ty};
                    end
                    SP_HY0: begin
                        w_op.a = {1'b0, w_y0};
                        w_op.b = {1'b0, K_HASH_Y};
                    end
                    SP_SMY: begin
                        w_op.a = {1'b0, r_tt};
                        w_op.b = {15'b0, SMOOTH_K - {1'b0, w_ty, 1'b0}};
                    end
                    SP_HY1: begin
                        w_op.a = {1'b0, w_y1};
                        w_op.b = {1'b0, K_HASH_Y};
                    end
                    SP_C00A: begin
                        w_op.a = {1'b0, xs16(r_hx0 ^ r_hy0 ^ r_seed)};
                        w_op.b = {1'b0, K_MIX_A};
                    end
                    SP_C10A: begin
                        w_op.a = {1'b0, xs16(r_hx1 ^ r_hy0 ^ r_seed)};
                        w_op.b = {1'b0, K_MIX_A};
                    end
                    SP_C01A: begin
                        w_op.a = {1'b0, xs16(r_hx0 ^ r_hy1 ^ r_seed)};
                        w_op.b = {1'b0, K_MIX_A};
                    end
                    SP_C11A: begin
                        w_op.a = {1'b0, xs16(r_hx1 ^ r_hy1 ^ r_seed)};
                        w_op.b = {1'b0, K_MIX_A};
                    end
                    SP_C00B, SP_C10B, SP_C01B, SP_C11B: begin
                        w_op.a = {1'b0, xs15(w_m)};
                        w_op.b = {1'b0, K_MIX_B};
                    end
                    SP_TOP: begin
                        w_op.a = {{8{w_dtop[24]}}, w_dtop};
                        w_op.b = {16'b0, r_sx};
                    end
                    SP_BOT: begin
                        w_op.a = {{8{w_dbot[24]}}, w_dbot};
                        w_op.b = {16'b0, r_sx};
                    end
                    SP_XLO: begin
                        w_op.a = {13'b0, r_x[19:0]};
                        w_op.b = {15'b0, SCALE_Q16};
                    end
                    SP_XHI: begin
                        w_op.a = {{13{r_x[39]}}, r_x[39:20]};
                        w_op.b = {15'b0, SCALE_Q16};
                    end
                    SP_VAL: begin
                        w_op.a = {{8{w_dval[24]}}, w_dval};
                        w_op.b = {16'b0, r_sy};
                    end
                    SP_YLO: begin
                        w_op.a = {13'b0, r_y[19:0]};
                        w_op.b = {15'b0, SCALE_Q16};
                    end
                    SP_YHI: begin
                        w_op.a = {{13{r_y[39]}}, r_y[39:20]};
                        w_op.b = {15'b0, SCALE_Q16};
                    end
                    default: begin
                        w_op.a = '0;
                        w_op.b = '0;
                    end
                endcase
            end
            S_NORM: begin
                w_op.a = {{(MUL_W - SUM_W){r_sum[SUM_W-1]}}, r_sum};
                w_op.b = {{(MUL_W - RECIP_W){1'b0}}, recip(r_k)};
            end
            default: begin
                w_op.a = '0;
                w_op.b = '0;
            end
        endcase
    end

    // sequencer: each step takes the product of the previous step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= SP_TTX;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_oct   <= '0;
            r_k     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_busy  <= 1'b1;
                        r_state <= S_OCT;
                        r_step  <= SP_TTX;
                        r_oct   <= '0;
                        r_k     <= w_k;
                        r_x     <= {{(COORD_W - IN_W){i_point_x[IN_W-1]}}, i_point_x};
                        r_y     <= {{(COORD_W - IN_W){i_point_y[IN_W-1]}}, i_point_y};
                        r_seed  <= i_noise_seed;
                        r_sum   <= '0;
                    end
                end
                S_OCT: begin
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        SP_HX0:  r_tt  <= r_prod[31:0];
                        SP_SMX:  r_hx0 <= w_m;
                        SP_HX1:  r_sx  <= r_prod[48:32];
                        SP_TTY:  r_hx1 <= w_m;
                        SP_HY0:  r_tt  <= r_prod[31:0];
                        SP_SMY:  r_hy0 <= w_m;
                        SP_HY1:  r_sy  <= r_prod[48:32];
                        SP_C00A: r_hy1 <= w_m;
                        SP_C10A: r_c00 <= w_corner;
                        SP_C01A: r_c10 <= w_corner;
                        SP_C11A: r_c01 <= w_corner;
                        SP_TOP:  r_c11 <= w_corner;
                        SP_BOT:  r_top <= r_c00 + w_sh[CORN_W-1:0];
                        SP_XLO:  r_bot <= r_c01 + w_sh[CORN_W-1:0];
                        SP_XHI:  r_plo <= r_prod[37:0];
                        SP_VAL:  r_x   <= w_coord;
                        SP_YLO:  r_sum <= r_sum + {{(SUM_W - 26){w_term[25]}}, w_term};
                        SP_YHI:  r_plo <= r_prod[37:0];
                        SP_LAST: begin
                            r_y    <= w_coord;
                            r_step <= SP_TTX;
                            r_seed <= r_seed + SEED_STEP;
                            if (r_oct == r_k - OCT_W'(1)) begin
                                r_state <= S_NORM;
                            end else begin
                                r_oct <= r_oct + OCT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_NORM: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_noise <= w_sat;
                    r_valid <= 1'b1;
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_noise_value = r_noise;

endmodule

[design/fvn_checker.sv]
// port-level checks for the fractal value noise block, bound to the top level
`include "fractal_value_noise_assert.svh"

module fvn_port_props (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [fvn_pkg::NOISE_W-1:0] o_noise_value
);
    import fvn_pkg::*;

    localparam logic signed [NOISE_W-1:0] LIM_HI = NOISE_W'(NOISE_MAX);
    localparam logic signed [NOISE_W-1:0] LIM_LO = -LIM_HI;

    logic w_in_range;

    assign w_in_range = (o_noise_value <= LIM_HI) && (o_noise_value >= LIM_LO);

    `FVN_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `FVN_ASSERT_IMP(a_value_range, i_clk, i_rst_n, o_valid, w_in_range)
    `FVN_ASSERT_IMP(a_done_with_result, i_clk, i_rst_n, $fell(busy), o_valid)
    `FVN_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

bind fractal_value_noise fvn_port_props u_fvn_port_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_noise_value (o_noise_value)
);

[tb/sv/fvn_checker.sv]
// checker for the fractal value noise block: predicts each request and compares results
`timescale 1ns / 1ps

module fvn_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [fvn_pkg::IN_W-1:0]           i_point_x,
    input  logic [fvn_pkg::IN_W-1:0]           i_point_y,
    input  logic [fvn_pkg::IN_W-1:0]           i_noise_seed,
    input  logic [fvn_pkg::OCT_W-1:0]          i_octave_count,
    input  logic                               i_valid,
    input  logic [fvn_pkg::NOISE_W-1:0]        i_noise_value,
    output int                                 o_pending,
    output int                                 o_fail_count
);

    localparam logic [31:0] LATTICE_MUL_X = 32'h9e3779b9;
    localparam logic [31:0] LATTICE_MUL_Y = 32'h85ebca6b;
    localparam logic [31:0] AVAL_MUL_A    = 32'h7feb352d;
    localparam logic [31:0] AVAL_MUL_B    = 32'h846ca68b;
    localparam int          OCTAVE_SEED_STEP = 1013;
    localparam longint      LACUNARITY_Q16   = 133038;
    localparam int          OCTAVE_LIMIT     = 8;

    typedef struct {
        logic [31:0]                  x;
        logic [31:0]                  y;
        logic [31:0]                  seed;
        logic [3:0]                   octaves;
        logic [fvn_pkg::NOISE_W-1:0]  noise;
    } noise_req_t;

    noise_req_t noise_expected[$];
    noise_req_t head;
    noise_req_t fresh;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic [31:0] avalanche(input logic [31:0] v);
        logic [31:0] h;
        h = v ^ (v >> 16);
        h = h * AVAL_MUL_A;
        h = h ^ (h >> 15);
        h = h * AVAL_MUL_B;
        return h ^ (h >> 16);
    endfunction

    function automatic longint lattice(input logic [31:0] cx, input logic [31:0] cy,
                                       input logic [31:0] seed);
        logic [31:0] h;
        h = avalanche((cx * LATTICE_MUL_X) ^ (cy * LATTICE_MUL_Y) ^ seed);
        return longint'(h[23:0]);
    endfunction

    function automatic longint wrap40(input longint v);
        logic signed [39:0] w;
        w = v[39:0];
        return longint'(w);
    endfunction

    function automatic longint ease(input longint t);
        return ((t * t) * (196608 - 2 * t)) >>> 32;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint s);
        return a + (((b - a) * s) >>> 16);
    endfunction

    // one octave in Q1.24
    function automatic longint octave_blend(input longint cx, input longint cy,
                                            input logic [31:0] seed);
        logic [31:0] x0;
        logic [31:0] y0;
        longint sx;
        longint sy;
        longint top;
        longint bot;
        x0  = cx[47:16];
        y0  = cy[47:16];
        sx  = ease(longint'(cx[15:0]));
        sy  = ease(longint'(cy[15:0]));
        top = blend(lattice(x0, y0, seed), lattice(x0 + 32'd1, y0, seed), sx);
        bot = blend(lattice(x0, y0 + 32'd1, seed), lattice(x0 + 32'd1, y0 + 32'd1, seed), sx);
        return 2 * blend(top, bot, sy) - (longint'(1) << 24);
    endfunction

    function automatic logic [fvn_pkg::NOISE_W-1:0] predict_noise(
        input logic [31:0] px, input logic [31:0] py,
        input logic [31:0] seed, input logic [3:0] octaves);
        longint cx;
        longint cy;
        longint sum;
        longint den;
        longint gain;
        longint r;
        int     k;
        cx  = longint'($signed(px));
        cy  = longint'($signed(py));
        k   = (octaves == 4'd0) ? 1 : ((octaves > OCTAVE_LIMIT) ? OCTAVE_LIMIT : int'(octaves));
        sum = 0;
        for (int o = 0; o < k; o++) begin
            sum += octave_blend(cx, cy, seed + 32'(OCTAVE_SEED_STEP * o)) >>> (o + 1);
            cx = wrap40((cx * LACUNARITY_Q16) >>> 16);
            cy = wrap40((cy * LACUNARITY_Q16) >>> 16);
        end
        den  = (longint'(1) << k) - 1;
        gain = ((longint'(1) << (16 + k)) + (den >>> 1)) / den;
        r    = (sum * gain + (longint'(1) << 23)) >>> 24;
        if (r > 65536)
            r = 65536;
        if (r < -65536)
            r = -65536;
        return r[fvn_pkg::NOISE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (o_fail_count < 40)
            $display("[%0t] noise check: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (noise_expected.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request waiting",
                                              $signed(i_noise_value)));
                end else begin
                    head = noise_expected.pop_front();
                    if (i_noise_value !== head.noise)
                        report_mismatch($sformatf(
                            "x=%h y=%h seed=%h oct=%0d: noise_value %0d, expected %0d",
                            head.x, head.y, head.seed, head.octaves,
                            $signed(i_noise_value), $signed(head.noise)));
                end
            end
            if (i_start && !i_busy) begin
                fresh.x       = i_point_x;
                fresh.y       = i_point_y;
                fresh.seed    = i_noise_seed;
                fresh.octaves = i_octave_count;
                fresh.noise   = predict_noise(i_point_x, i_point_y, i_noise_seed,
                                              i_octave_count);
                noise_expected.push_back(fresh);
            end
            o_pending <= noise_expected.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// top of the fractal value noise testbench: clock, reset, requests and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int STALL_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 200;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic signed [fvn_pkg::IN_W-1:0]    i_point_x;
    logic signed [fvn_pkg::IN_W-1:0]    i_point_y;
    logic [fvn_pkg::IN_W-1:0]           i_noise_seed;
    logic [fvn_pkg::OCT_W-1:0]          i_octave_count;
    logic                               o_valid;
    logic signed [fvn_pkg::NOISE_W-1:0] o_noise_value;

    int pending;
    int fail_count;
    int quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fractal_value_noise u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_noise_seed   (i_noise_seed),
        .i_octave_count (i_octave_count),
        .o_valid        (o_valid),
        .o_noise_value  (o_noise_value)
    );

    fvn_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_noise_seed   (i_noise_seed),
        .i_octave_count (i_octave_count),
        .i_valid        (o_valid),
        .i_noise_value  (o_noise_value),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // watchdog on cycles with neither a request nor a result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] seed, input logic [3:0] octaves,
                                input int idle_pct);
        i_point_x      <= x;
        i_point_y      <= y;
        i_noise_seed   <= seed;
        i_octave_count <= octaves;
        start          <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] c;
        case ($urandom_range(5))
            0: c = $urandom;
            1: c = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            2: c = {16'($urandom_range(0, 16'hffff)), $urandom_range(1) ? 16'hffff : 16'h0000};
            3: c = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                     : 32'h8000_0000 + $urandom_range(3);
            4: c = 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
            default: c = {16'($urandom_range(0, 16'hffff)), 16'h8000};
        endcase
        return c;
    endfunction

    function automatic logic [3:0] pick_octaves();
        if ($urandom_range(99) < 60)
            return 4'($urandom_range(0, 4));
        return 4'($urandom_range(0, 15));
    endfunction

    initial begin
        int idle_pct;
        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_point_x      <= '0;
        i_point_y      <= '0;
        i_noise_seed   <= '0;
        i_octave_count <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero octaves, one octave, fraction edges, extreme coordinates and seeds
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd0, 0);
        send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd1, 0);
        send_request(32'h0000_ffff, 32'h0000_ffff, 32'hffff_ffff, 4'd1, 0);
        send_request(32'h0000_8000, 32'h0000_8000, 32'hdead_beef, 4'd4, 0);
        send_request(32'h0001_0000, 32'hffff_0000, 32'h0000_0001, 4'd3, 0);
        send_request(32'hffff_ffff, 32'hffff_ffff, 32'ha5a5_a5a5, 4'd2, 0);
        // coordinates that overflow the scaled range over eight octaves
        send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678, 4'd8, 0);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 4'd8, 0);
        send_request(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 4'd15, 0);
        send_request(32'h8000_0000, 32'h7fff_ffff, 32'h5a5a_5a5a, 4'd9, 0);
        send_request(32'h0123_4567, 32'h89ab_cdef, 32'h0f0f_0f0f, 4'd5, 0);
        send_request(32'hfedc_ba98, 32'h7654_3210, 32'hf0f0_f0f0, 4'd6, 0);
        send_request(32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 4'd7, 0);
        send_request(32'h0000_0000, 32'h7fff_0000, 32'h0000_ffff, 4'd10, 0);
        send_request(32'h8000_ffff, 32'h0000_0000, 32'hffff_0000, 4'd12, 0);
        send_request(32'h4000_0000, 32'hc000_0000, 32'h3333_3333, 4'd14, 0);
        // seed wraps past the top while stepping through octaves
        send_request(32'h1234_5678, 32'h9abc_def0, 32'hffff_fc00, 4'd8, 0);
        send_request(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 4'd15, 0);
        send_request(32'hffff_8000, 32'h0000_7fff, 32'h0000_0000, 4'd11, 0);
        send_request(32'h0003_0000, 32'hfffd_0000, 32'h7fff_ffff, 4'd13, 0);
        start <= 1'b0;
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 16 : ((phase == 1) ? 74 : 0);
            for (int n = 0; n < RANDOM_REQUESTS / 3; n++) begin
                send_request(pick_coord(), pick_coord(), $urandom, pick_octaves(), idle_pct);
                // hold off now and then until every request has its result
                if ($urandom_range(63) == 0) begin
                    start <= 1'b0;
                    drain_results();
                end
            end
            start <= 1'b0;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[fractal_value_noise.f]
+incdir+design
design/fvn_pkg.sv
design/fvn_mul.sv
design/fractal_value_noise.sv
design/fvn_checker.sv
tb/sv/fvn_checker.sv
tb/sv/testbench.sv
